### sv/hrft_pkg.sv
// Package for the HTTP request field tagger: field tags, method codes,
// character codes, the result struct and the method-matching helpers.
// No dependencies.
package hrft_pkg;

    // Field tags
    localparam logic [2:0] TAG_METHOD  = 3'd0;
    localparam logic [2:0] TAG_HOST    = 3'd1;
    localparam logic [2:0] TAG_PATH    = 3'd2;
    localparam logic [2:0] TAG_VERSION = 3'd3;
    localparam logic [2:0] TAG_KEY     = 3'd4;
    localparam logic [2:0] TAG_VALUE   = 3'd5;
    localparam logic [2:0] TAG_BODY    = 3'd6;
    localparam logic [2:0] TAG_DELIM   = 3'd7;

    // Method codes
    localparam logic [1:0] MCODE_GET     = 2'd0;
    localparam logic [1:0] MCODE_POST    = 2'd1;
    localparam logic [1:0] MCODE_CONNECT = 2'd2;
    localparam logic [1:0] MCODE_OTHER   = 2'd3;

    // Characters
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_COLON = 8'h3a;

    // Slash number that starts the path
    localparam logic [1:0] PATH_SLASH = 2'd3;

    // Method matcher: position saturates here, all candidates live at reset
    localparam logic [2:0] MATCH_POS_MAX = 3'd7;
    localparam logic [2:0] MATCH_LIVE_ALL = 3'b111;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] field_tag;
        logic       method_valid;
        logic [1:0] method_code;
        logic       line_to_body;
        logic       out_last;
    } result_t;

    // Length of candidate method k (0 GET, 1 POST, 2 CONNECT)
    function automatic logic [2:0] cand_len(input logic [1:0] k);
        logic [2:0] len;
        case (k)
            2'd0:    len = 3'd3;
            2'd1:    len = 3'd4;
            2'd2:    len = 3'd7;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    // Character of candidate k at position pos (0 past its end)
    function automatic logic [7:0] cand_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (k)
            2'd0:
                case (pos)
                    3'd0:    ch = "G";
                    3'd1:    ch = "E";
                    3'd2:    ch = "T";
                    default: ch = 8'h00;
                endcase
            2'd1:
                case (pos)
                    3'd0:    ch = "P";
                    3'd1:    ch = "O";
                    3'd2:    ch = "S";
                    3'd3:    ch = "T";
                    default: ch = 8'h00;
                endcase
            2'd2:
                case (pos)
                    3'd0:    ch = "C";
                    3'd1:    ch = "O";
                    3'd2:    ch = "N";
                    3'd3:    ch = "N";
                    3'd4:    ch = "E";
                    3'd5:    ch = "C";
                    3'd6:    ch = "T";
                    default: ch = 8'h00;
                endcase
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // First live candidate whose full length has been matched
    function automatic logic [1:0] match_code(input logic [2:0] pos, input logic [2:0] live);
        logic [1:0] code;
        if (live[0] && pos == cand_len(2'd0)) begin
            code = MCODE_GET;
        end else if (live[1] && pos == cand_len(2'd1)) begin
            code = MCODE_POST;
        end else if (live[2] && pos == cand_len(2'd2)) begin
            code = MCODE_CONNECT;
        end else begin
            code = MCODE_OTHER;
        end
        return code;
    endfunction

endpackage

### sv/hrft_parser.sv
// Parser core of the HTTP request field tagger: phase state, method matcher
// and the registered result. Depends on hrft_pkg.
module hrft_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output hrft_pkg::result_t    result
);

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_URL,
        PH_VERSION,
        PH_HDR_START,
        PH_HDR_LINE,
        PH_BODY
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [1:0]        slash_reg, slash_next;
    logic [2:0]        pos_reg, pos_next;
    logic [2:0]        live_reg, live_next;
    logic              colon_reg, colon_next;
    logic              spaces_reg, spaces_next;
    logic              cr_reg, cr_next;
    hrft_pkg::result_t result_reg, result_next;

    logic       eol;
    logic [2:0] adv_live;
    logic [2:0] adv_pos;

    assign eol = (data_byte == hrft_pkg::CH_CR) || (data_byte == hrft_pkg::CH_LF);

    // Method matcher advance: each candidate checked on its own
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            adv_live[k] = live_reg[k] && (pos_reg < hrft_pkg::cand_len(2'(k)))
                && (hrft_pkg::cand_char(2'(k), pos_reg) == data_byte);
        end
        adv_pos = (pos_reg < hrft_pkg::MATCH_POS_MAX) ? pos_reg + 3'd1 : pos_reg;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        slash_next  = slash_reg;
        pos_next    = pos_reg;
        live_next   = live_reg;
        colon_next  = colon_reg;
        spaces_next = spaces_reg;
        cr_next     = 1'b0;

        result_next.out_byte     = data_byte;
        result_next.field_tag    = hrft_pkg::TAG_DELIM;
        result_next.method_valid = 1'b0;
        result_next.method_code  = hrft_pkg::MCODE_GET;
        result_next.line_to_body = 1'b0;
        result_next.out_last     = last_byte;

        unique case (phase_reg)
            PH_METHOD:
            begin
                if (data_byte == hrft_pkg::CH_SP) begin
                    result_next.method_valid = 1'b1;
                    result_next.method_code  = hrft_pkg::match_code(pos_reg, live_reg);
                    phase_next = PH_URL;
                end else begin
                    result_next.field_tag = hrft_pkg::TAG_METHOD;
                    pos_next  = adv_pos;
                    live_next = adv_live;
                    if (last_byte) begin
                        result_next.method_valid = 1'b1;
                        result_next.method_code  = hrft_pkg::match_code(adv_pos, adv_live);
                    end
                end
            end
            PH_URL:
            begin
                if (data_byte == hrft_pkg::CH_SP) begin
                    phase_next = PH_VERSION;
                end else if (slash_reg == hrft_pkg::PATH_SLASH) begin
                    result_next.field_tag = hrft_pkg::TAG_PATH;
                end else if (data_byte == hrft_pkg::CH_SLASH) begin
                    slash_next = slash_reg + 2'd1;
                    result_next.field_tag = (slash_next == hrft_pkg::PATH_SLASH)
                        ? hrft_pkg::TAG_PATH : hrft_pkg::TAG_HOST;
                end else begin
                    result_next.field_tag = hrft_pkg::TAG_HOST;
                end
            end
            PH_VERSION:
            begin
                if (eol) begin
                    cr_next    = (data_byte == hrft_pkg::CH_CR);
                    phase_next = PH_HDR_START;
                end else begin
                    result_next.field_tag = hrft_pkg::TAG_VERSION;
                end
            end
            PH_BODY:
            begin
                if (!(cr_reg && data_byte == hrft_pkg::CH_LF)) begin
                    result_next.field_tag = hrft_pkg::TAG_BODY;
                end
            end
            PH_HDR_START, PH_HDR_LINE:
            begin
                if (phase_reg == PH_HDR_START && cr_reg && data_byte == hrft_pkg::CH_LF) begin
                    // LF of the previous line's CR LF: delimiter, still at line start
                    result_next.field_tag = hrft_pkg::TAG_DELIM;
                end else if (phase_reg == PH_HDR_START && eol) begin
                    // empty line ends the headers
                    cr_next    = (data_byte == hrft_pkg::CH_CR);
                    phase_next = PH_BODY;
                end else begin
                    phase_next = PH_HDR_LINE;
                    if (!colon_reg) begin
                        if (data_byte == hrft_pkg::CH_COLON) begin
                            colon_next  = 1'b1;
                            spaces_next = 1'b1;
                        end else if (eol || last_byte) begin
                            result_next.field_tag    = hrft_pkg::TAG_BODY;
                            result_next.line_to_body = 1'b1;
                            phase_next = PH_BODY;
                        end else begin
                            result_next.field_tag = hrft_pkg::TAG_KEY;
                        end
                    end else if (eol) begin
                        cr_next     = (data_byte == hrft_pkg::CH_CR);
                        colon_next  = 1'b0;
                        spaces_next = 1'b0;
                        phase_next  = PH_HDR_START;
                    end else if (spaces_reg && data_byte == hrft_pkg::CH_SP) begin
                        result_next.field_tag = hrft_pkg::TAG_DELIM;
                    end else begin
                        result_next.field_tag = hrft_pkg::TAG_VALUE;
                        spaces_next = 1'b0;
                    end
                end
            end
            default:
            begin
                phase_next = PH_METHOD;
            end
        endcase

        // end of request: back to the start state
        if (last_byte) begin
            phase_next  = PH_METHOD;
            slash_next  = 2'd0;
            pos_next    = 3'd0;
            live_next   = hrft_pkg::MATCH_LIVE_ALL;
            colon_next  = 1'b0;
            spaces_next = 1'b0;
            cr_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_METHOD;
            slash_reg  <= 2'd0;
            pos_reg    <= 3'd0;
            live_reg   <= hrft_pkg::MATCH_LIVE_ALL;
            colon_reg  <= 1'b0;
            spaces_reg <= 1'b0;
            cr_reg     <= 1'b0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            slash_reg  <= slash_next;
            pos_reg    <= pos_next;
            live_reg   <= live_next;
            colon_reg  <= colon_next;
            spaces_reg <= spaces_next;
            cr_reg     <= cr_next;
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        if (step_en) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

### sv/http_request_field_tagger.sv
// Top level of the HTTP request field tagger: input register, handshake
// control and the parser core. Depends on hrft_pkg and hrft_parser.
//
// The tagger takes an HTTP request one byte at a time on the input channel
// and returns one result per byte: the byte itself, a field tag (method,
// host, path, version, header key, header value, body, delimiter), the method
// code when the method token ends, a flag when a colonless header line turns
// the rest into body, and a copy of the end-of-request mark. It sustains one
// byte per clock while the output is not stalled. A byte sits in the input
// register, then the phase logic writes its result into the result register,
// which drives the output ports. Both registers advance together; a stall on
// the output freezes them and is passed back as in_stall in the same cycle.
// After a byte with last_byte set, all parse state returns to its reset value
// so the next byte starts a new request.
module http_request_field_tagger
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [2:0] field_tag,
    output logic       method_valid,
    output logic [1:0] method_code,
    output logic       line_to_body,
    output logic       out_last
);

    logic              s1_valid_reg, s1_valid_next;
    logic [7:0]        s1_byte_reg;
    logic              s1_last_reg;
    logic              out_valid_reg, out_valid_next;
    logic              advance;
    hrft_pkg::result_t result;

    // pipeline moves whenever the result register is free or being taken
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    assign s1_valid_next  = advance ? in_valid : s1_valid_reg;
    assign out_valid_next = advance ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (advance) begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    // parser state and result step only on a real byte
    hrft_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance && s1_valid_reg),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .result    (result)
    );

    assign out_valid    = out_valid_reg;
    assign out_byte     = result.out_byte;
    assign field_tag    = result.field_tag;
    assign method_valid = result.method_valid;
    assign method_code  = result.method_code;
    assign line_to_body = result.line_to_body;
    assign out_last     = result.out_last;

endmodule

### sv/hrft_checker.sv
// Port-level checker for the HTTP request field tagger, with its bind.
// Depends on hrft_pkg and http_request_field_tagger.
module hrft_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] field_tag,
    input logic       method_valid,
    input logic [1:0] method_code,
    input logic       line_to_body
);

    // a stalled result is held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // method ends only on a method byte or its delimiting space
    a_method_tag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && method_valid |->
            (field_tag == hrft_pkg::TAG_METHOD || field_tag == hrft_pkg::TAG_DELIM))
        else $error("method_valid on a non-method byte");

    // method code is zero unless a method ended
    a_method_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !method_valid |-> method_code == hrft_pkg::MCODE_GET)
        else $error("method_code set without method_valid");

    // colonless line end is tagged body
    a_to_body: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_to_body |-> field_tag == hrft_pkg::TAG_BODY && !method_valid)
        else $error("line_to_body on a non-body byte");

endmodule

bind http_request_field_tagger hrft_checker u_hrft_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .field_tag    (field_tag),
    .method_valid (method_valid),
    .method_code  (method_code),
    .line_to_body (line_to_body)
);
